[rtl/core/olf_pkg.sv]
package olf_pkg;

  // Header words that open a record
  localparam logic [15:0] HDR_CODE   = 16'hCADE;
  localparam logic [15:0] HDR_DATA   = 16'hDADA;
  localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;

  // Address space of the presence map
  localparam int unsigned ADDR_W = 16;

  typedef enum logic [3:0] {
    PH_HDR_HI,
    PH_HDR_LO,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_WORD_HI,
    PH_WORD_LO,
    PH_SYM_ADDR_HI,
    PH_SYM_ADDR_LO,
    PH_SYM_LEN_HI,
    PH_SYM_LEN_LO,
    PH_LABEL
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_LABEL,
    KIND_END
  } kind_e;

  typedef enum logic [1:0] {
    SEC_CODE,
    SEC_DATA,
    SEC_FILL
  } section_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  section;
    logic [15:0] address;
    logic [15:0] word_value;
    logic [7:0]  label_char;
    logic        label_last;
    logic        end_status;
  } result_t;

  // Requests from the parser to the presence map
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } map_req_t;

endpackage

[rtl/core/object_file_section_loader.sv]
// Object file loader: takes one byte of the file per cycle when not stalled
// and reports memory writes, label characters and the end of the stream in
// order. A byte causes zero, one or two results; these go into a four-entry
// result queue, and after the sweep a byte is taken whenever that queue has
// room for two, so a steady one byte per cycle is sustained while the output
// side takes results as fast as they come. After reset the 65536-entry
// presence memory is swept clear, one entry a cycle; no byte is taken during it.
module object_file_section_loader (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  olf_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output olf_pkg::result_t  out_data_o
);
  import olf_pkg::*;

  map_req_t   map_req;
  logic       present;
  logic       map_ready;
  logic       space;
  logic       fire;
  logic [1:0] push_n;
  result_t    res0;
  result_t    res1;
  logic [2:0] q_count;
  phase_e     phase;

  // A byte is taken once the map is clear and the queue has two free slots.
  assign in_ready_o = map_ready && space;
  assign fire       = in_valid_i && in_ready_o;

  olf_presence u_presence (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .present_o (present),
    .ready_o   (map_ready)
  );

  olf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_data_i),
    .present_i (present),
    .req_o     (map_req),
    .push_n_o  (push_n),
    .res0_o    (res0),
    .res1_o    (res1),
    .phase_o   (phase)
  );

  olf_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .res0_i      (res0),
    .res1_i      (res1),
    .space_o     (space),
    .count_o     (q_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The queue never holds more than its four slots.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= 3'd4)
    else $error("result queue overflow");

  // Nothing is pushed unless a byte is transferred.
  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> fire)
    else $error("result pushed without an input transfer");

  // No presence write competes with the clearing sweep.
  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !map_ready |-> !map_req.wr_en)
    else $error("presence write during clearing sweep");

  // End of stream always returns the parser to header search.
  a_eos_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_data_i.end_of_stream) |=> (phase == PH_HDR_HI))
    else $error("parser not back at header after end of stream");

endmodule

[rtl/core/olf_presence.sv]
module olf_presence (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  olf_pkg::map_req_t req_i,
  output logic              present_o,
  output logic              ready_o
);
  import olf_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic             mem [DEPTH];
  logic [ADDR_W:0]  clr_q, clr_d;
  logic             busy;
  logic             present_q;

  // The clearing sweep is running until the counter reaches the depth.
  assign busy    = !clr_q[ADDR_W];
  assign ready_o = !busy;
  assign clr_d   = clr_q + {{ADDR_W{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy) begin
      clr_q <= clr_d;
    end
  end

  // One port writes: the sweep clears, afterwards the parser marks entries.
  always_ff @(posedge clk_i) begin
    if (busy) begin
      mem[clr_q[ADDR_W-1:0]] <= 1'b0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= 1'b1;
    end
  end

  // Registered lookup, held until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      present_q <= mem[req_i.rd_addr];
    end
  end

  assign present_o = present_q;

endmodule

[rtl/core/olf_result_queue.sv]
module olf_result_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  olf_pkg::result_t res0_i,
  input  olf_pkg::result_t res1_i,
  output logic             space_o,
  output logic [2:0]       count_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output olf_pkg::result_t out_data_o
);
  import olf_pkg::*;

  result_t    entries_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = entries_q[rd_ptr_q];
  // Room for the two results that one byte may cause.
  assign space_o     = (count_q <= 3'd2);
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n_i;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_n_i} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Results of one byte land in consecutive slots.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      entries_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      entries_q[wr_ptr_q + 2'd1] <= res1_i;
    end
  end

endmodule

[rtl/core/olf_parser.sv]
module olf_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  olf_pkg::in_item_t  item_i,
  input  logic               present_i,
  output olf_pkg::map_req_t  req_o,
  output logic [1:0]         push_n_o,
  output olf_pkg::result_t   res0_o,
  output olf_pkg::result_t   res1_o,
  output olf_pkg::phase_e    phase_o
);
  import olf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  hold_q, hold_d;
  logic [1:0]  sec_q, sec_d;
  logic [15:0] cursor_q, cursor_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] label_q, label_d;
  logic [15:0] highest_q, highest_d;
  logic [15:0] w;
  logic [15:0] remain_dec;
  logic [15:0] reloc;
  logic [7:0]  b;

  assign b          = item_i.data_byte;
  assign w          = {hold_q, b};
  assign remain_dec = remain_q - 16'd1;
  assign reloc      = highest_q + 16'd1;
  assign phase_o    = phase_q;

  // Next state of the parser for the transfer in this cycle.
  always_comb begin
    phase_d   = phase_q;
    hold_d    = hold_q;
    sec_d     = sec_q;
    cursor_d  = cursor_q;
    remain_d  = remain_q;
    label_d   = label_q;
    highest_d = highest_q;
    if (fire_i) begin
      if (item_i.end_of_stream) begin
        phase_d = PH_HDR_HI;
      end else begin
        case (phase_q)
          PH_HDR_HI: begin
            hold_d  = b;
            phase_d = PH_HDR_LO;
          end
          PH_HDR_LO: begin
            if (w == HDR_CODE) begin
              sec_d   = SEC_CODE;
              phase_d = PH_ADDR_HI;
            end else if (w == HDR_DATA) begin
              sec_d   = SEC_DATA;
              phase_d = PH_ADDR_HI;
            end else if (w == HDR_SYMBOL) begin
              phase_d = PH_SYM_ADDR_HI;
            end else begin
              phase_d = PH_HDR_HI;
            end
          end
          PH_ADDR_HI: begin
            hold_d  = b;
            phase_d = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            cursor_d = w;
            phase_d  = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            hold_d  = b;
            phase_d = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            remain_d = w;
            phase_d  = (w == 16'd0) ? PH_HDR_HI : PH_WORD_HI;
          end
          PH_WORD_HI: begin
            hold_d  = b;
            phase_d = PH_WORD_LO;
          end
          PH_WORD_LO: begin
            cursor_d  = cursor_q + 16'd1;
            remain_d  = remain_dec;
            highest_d = (cursor_q > highest_q) ? cursor_q : highest_q;
            phase_d   = (remain_dec == 16'd0) ? PH_HDR_HI : PH_WORD_HI;
          end
          PH_SYM_ADDR_HI: begin
            hold_d  = b;
            phase_d = PH_SYM_ADDR_LO;
          end
          PH_SYM_ADDR_LO: begin
            label_d = w;
            phase_d = PH_SYM_LEN_HI;
          end
          PH_SYM_LEN_HI: begin
            hold_d  = b;
            phase_d = PH_SYM_LEN_LO;
          end
          PH_SYM_LEN_LO: begin
            remain_d = w;
            if (!present_i) begin
              label_d   = reloc;
              highest_d = (reloc > highest_q) ? reloc : highest_q;
            end
            phase_d = (w == 16'd0) ? PH_HDR_HI : PH_LABEL;
          end
          PH_LABEL: begin
            remain_d = remain_dec;
            if (remain_dec == 16'd0) begin
              phase_d = PH_HDR_HI;
            end
          end
          default: begin
            phase_d = PH_HDR_HI;
          end
        endcase
      end
    end
  end

  // Results and presence map requests for the transfer in this cycle.
  always_comb begin
    push_n_o = 2'd0;
    res0_o   = '0;
    res1_o   = '0;
    req_o    = '0;
    if (fire_i) begin
      if (item_i.end_of_stream) begin
        res0_o.result_kind = KIND_END;
        res0_o.end_status  = (phase_q != PH_HDR_HI);
        push_n_o           = 2'd1;
      end else begin
        case (phase_q)
          PH_WORD_LO: begin
            res0_o.result_kind = KIND_WRITE;
            res0_o.section     = sec_q;
            res0_o.address     = cursor_q;
            res0_o.word_value  = w;
            push_n_o           = 2'd1;
            req_o.wr_en        = 1'b1;
            req_o.wr_addr      = cursor_q;
          end
          PH_SYM_ADDR_LO: begin
            // Look the symbol address up while its length arrives.
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = w;
          end
          PH_SYM_LEN_LO: begin
            if (!present_i) begin
              res0_o.result_kind = KIND_WRITE;
              res0_o.section     = SEC_FILL;
              res0_o.address     = reloc;
              req_o.wr_en        = 1'b1;
              req_o.wr_addr      = reloc;
              if (w == 16'd0) begin
                res1_o.result_kind = KIND_LABEL;
                res1_o.address     = reloc;
                res1_o.label_last  = 1'b1;
                push_n_o           = 2'd2;
              end else begin
                push_n_o = 2'd1;
              end
            end else if (w == 16'd0) begin
              res0_o.result_kind = KIND_LABEL;
              res0_o.address     = label_q;
              res0_o.label_last  = 1'b1;
              push_n_o           = 2'd1;
            end
          end
          PH_LABEL: begin
            res0_o.result_kind = KIND_LABEL;
            res0_o.address     = label_q;
            res0_o.label_char  = b;
            if (remain_dec == 16'd0) begin
              res1_o.result_kind = KIND_LABEL;
              res1_o.address     = label_q;
              res1_o.label_last  = 1'b1;
              push_n_o           = 2'd2;
            end else begin
              push_n_o = 2'd1;
            end
          end
          default: begin
            push_n_o = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR_HI;
      hold_q    <= '0;
      sec_q     <= '0;
      cursor_q  <= '0;
      remain_q  <= '0;
      label_q   <= '0;
      highest_q <= '0;
    end else begin
      phase_q   <= phase_d;
      hold_q    <= hold_d;
      sec_q     <= sec_d;
      cursor_q  <= cursor_d;
      remain_q  <= remain_d;
      label_q   <= label_d;
      highest_q <= highest_d;
    end
  end

endmodule

[dv/object_file_section_loader_test.sv]
`timescale 1ns / 1ps

module object_file_section_loader_test;
  import olf_pkg::*;

  // One row of the byte feed; where typed is set, the expected results are given by hand.
  typedef struct {
    in_item_t    item;
    bit          typed;
    int unsigned n_typed;
    result_t     r0;
    result_t     r1;
  } feed_row_t;

  localparam int unsigned NumDirected = 30;
  localparam int unsigned NumRandom   = 1650;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_item_t in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  result_t  out_data_o;

  object_file_section_loader i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Predicted loader state, as it stands after reset.
  phase_e      phase       = PH_HDR_HI;
  logic [7:0]  held_byte   = '0;
  section_e    cur_section = SEC_CODE;
  logic [15:0] cursor      = '0;
  logic [15:0] words_left  = '0;
  logic [15:0] label_at    = '0;
  logic [15:0] top_address = '0;
  bit          written_map [65536];

  feed_row_t   feed_q [$];
  result_t     pending_results [$];
  int unsigned bytes_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  bit          held_once      = 1'b0;

  function automatic result_t mem_write(section_e sec, logic [15:0] addr, logic [15:0] word);
    result_t r;
    r             = '0;
    r.result_kind = KIND_WRITE;
    r.section     = sec;
    r.address     = addr;
    r.word_value  = word;
    return r;
  endfunction

  function automatic result_t label_out(logic [15:0] addr, logic [7:0] ch, logic last);
    result_t r;
    r             = '0;
    r.result_kind = KIND_LABEL;
    r.address     = addr;
    r.label_char  = ch;
    r.label_last  = last;
    return r;
  endfunction

  function automatic result_t stream_end(logic status);
    result_t r;
    r             = '0;
    r.result_kind = KIND_END;
    r.end_status  = status;
    return r;
  endfunction

  // Records a memory write in the presence map and tracks the highest address.
  function automatic void note_write(logic [15:0] addr);
    written_map[addr] = 1'b1;
    if (addr > top_address) begin
      top_address = addr;
    end
  endfunction

  // Advances the predicted parser by one byte and returns the results it causes.
  function automatic void load_byte(input in_item_t it, output result_t res [2],
                                    output int unsigned n);
    logic [15:0] w;
    w      = {held_byte, it.data_byte};
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (it.end_of_stream) begin
      res[0] = stream_end(phase != PH_HDR_HI);
      n      = 1;
      phase  = PH_HDR_HI;
      return;
    end
    case (phase)
      PH_HDR_LO: begin
        if (w == HDR_CODE) begin
          cur_section = SEC_CODE;
          phase       = PH_ADDR_HI;
        end else if (w == HDR_DATA) begin
          cur_section = SEC_DATA;
          phase       = PH_ADDR_HI;
        end else if (w == HDR_SYMBOL) begin
          phase = PH_SYM_ADDR_HI;
        end else begin
          phase = PH_HDR_HI;
        end
      end
      PH_ADDR_LO: begin
        cursor = w;
        phase  = PH_CNT_HI;
      end
      PH_CNT_LO: begin
        words_left = w;
        phase      = (w == 16'h0000) ? PH_HDR_HI : PH_WORD_HI;
      end
      PH_WORD_LO: begin
        res[n] = mem_write(cur_section, cursor, w);
        n      = n + 1;
        note_write(cursor);
        cursor     = cursor + 16'd1;
        words_left = words_left - 16'd1;
        phase      = (words_left == 16'h0000) ? PH_HDR_HI : PH_WORD_HI;
      end
      PH_SYM_ADDR_LO: begin
        label_at = w;
        phase    = PH_SYM_LEN_HI;
      end
      PH_SYM_LEN_LO: begin
        words_left = w;
        // A label at an address never written moves just past the highest one.
        if (!written_map[label_at]) begin
          label_at = top_address + 16'd1;
          res[n]   = mem_write(SEC_FILL, label_at, 16'h0000);
          n        = n + 1;
          note_write(label_at);
        end
        if (w == 16'h0000) begin
          res[n] = label_out(label_at, 8'h00, 1'b1);
          n      = n + 1;
          phase  = PH_HDR_HI;
        end else begin
          phase = PH_LABEL;
        end
      end
      PH_LABEL: begin
        res[n]     = label_out(label_at, it.data_byte, 1'b0);
        n          = n + 1;
        words_left = words_left - 16'd1;
        if (words_left == 16'h0000) begin
          res[n] = label_out(label_at, 8'h00, 1'b1);
          n      = n + 1;
          phase  = PH_HDR_HI;
        end
      end
      PH_HDR_HI, PH_ADDR_HI, PH_CNT_HI, PH_WORD_HI, PH_SYM_ADDR_HI, PH_SYM_LEN_HI: begin
        held_byte = it.data_byte;
        phase     = phase_e'(phase + 1);
      end
      default: begin
        phase = PH_HDR_HI;
      end
    endcase
  endfunction

  function automatic feed_row_t plain(logic [7:0] b, logic eos = 1'b0);
    feed_row_t row;
    row.item.data_byte     = b;
    row.item.end_of_stream = eos;
    row.typed              = 1'b0;
    row.n_typed            = 0;
    row.r0                 = '0;
    row.r1                 = '0;
    return row;
  endfunction

  function automatic feed_row_t chk(logic [7:0] b, logic eos, int unsigned n, result_t r0,
                                    result_t r1 = '0);
    feed_row_t row;
    row         = plain(b, eos);
    row.typed   = 1'b1;
    row.n_typed = n;
    row.r0      = r0;
    row.r1      = r1;
    return row;
  endfunction

  task automatic add_byte(logic [7:0] b);
    feed_q.push_back(plain(b));
  endtask

  task automatic add_word(logic [15:0] w);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endtask

  // Mostly a small window so that rewrites and present labels are common.
  function automatic logic [15:0] pick_address();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      return 16'($urandom_range(0, 63));
    end else if (sel < 80) begin
      return 16'($urandom_range(16'hFFF0, 16'hFFFF));
    end
    return 16'($urandom);
  endfunction

  // Appends one record of random shape: mostly well formed, some cut short or noise.
  task automatic add_record();
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [15:0] hdr;
    logic [7:0]  part [$];
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      add_word($urandom_range(0, 1) ? HDR_CODE : HDR_DATA);
      add_word(pick_address());
      if ($urandom_range(0, 6) == 0) begin
        len = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 20);
      end else begin
        len = $urandom_range(1, 6);
      end
      add_word(16'(len));
      repeat (len) add_word(16'($urandom));
    end else if (kind < 70) begin
      add_word(HDR_SYMBOL);
      add_word(pick_address());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
      add_word(16'(len));
      repeat (len) add_byte(8'($urandom));
    end else if (kind < 80) begin
      // A record with random fields, counts included, cut off by the end of stream.
      case ($urandom_range(0, 2))
        0:       hdr = HDR_CODE;
        1:       hdr = HDR_DATA;
        default: hdr = HDR_SYMBOL;
      endcase
      part.push_back(hdr[15:8]);
      part.push_back(hdr[7:0]);
      repeat (14) part.push_back(8'($urandom));
      cut = $urandom_range(1, part.size() - 1);
      for (int unsigned k = 0; k < cut; k++) begin
        add_byte(part[k]);
      end
      feed_q.push_back(plain(8'($urandom), 1'b1));
    end else if (kind < 88) begin
      // Header words that open nothing, some of them a near miss.
      if ($urandom_range(0, 1)) begin
        add_word(16'($urandom));
      end else begin
        add_word({($urandom_range(0, 1) ? HDR_CODE[15:8] : HDR_SYMBOL[15:8]), 8'($urandom)});
      end
    end else if (kind < 94) begin
      feed_q.push_back(plain(8'($urandom), 1'b1));
    end else begin
      add_byte(8'($urandom));
      feed_q.push_back(plain(8'($urandom), 1'b1));
    end
  endtask

  task automatic report_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected kind %0d sec %0d addr %h word %h char %h last %0b status %0b",
               want.result_kind, want.section, want.address, want.word_value,
               want.label_char, want.label_last, want.end_status);
      $display("  actual   kind %0d sec %0d addr %h word %h char %h last %0b status %0b",
               got.result_kind, got.section, got.address, got.word_value,
               got.label_char, got.label_last, got.end_status);
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Checks each result transfer and predicts from each byte transfer.
  always @(posedge clk_i) begin : scoreboard
    result_t     pred [2];
    int unsigned n_pred;
    feed_row_t   row;
    result_t     want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, out_data_o);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o !== want) begin
            report_mismatch("result differs", want, out_data_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        row = feed_q[bytes_taken];
        bytes_taken++;
        load_byte(in_data_i, pred, n_pred);
        if (row.typed) begin
          if (row.n_typed > 0) pending_results.push_back(row.r0);
          if (row.n_typed > 1) pending_results.push_back(row.r1);
        end else begin
          for (int unsigned k = 0; k < n_pred; k++) begin
            pending_results.push_back(pred[k]);
          end
        end
      end
    end
  end

  // Result side: stall patterns that change now and then, and one long hold-off.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(posedge clk_i);
        if (!held_once && results_seen >= 60) begin
          held_once = 1'b1;
          out_ready_i <= 1'b0;
          repeat (400) @(posedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Byte side: directed table first, then random records, sent in bursts.
  initial begin : byte_source
    feed_row_t   directed [NumDirected];
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;

    directed = '{
      // End of stream between records.
      chk(8'h00, 1'b1, 1, stream_end(1'b0)),
      // Empty label at an unwritten address with nothing written: fill at 1, terminator.
      plain(8'hC3), plain(8'hB7), plain(8'h12), plain(8'h34), plain(8'h00),
      chk(8'h00, 1'b0, 2, mem_write(SEC_FILL, 16'h0001, 16'h0000),
          label_out(16'h0001, 8'h00, 1'b1)),
      // One code word at the top address.
      plain(8'hCA), plain(8'hDE), plain(8'hFF), plain(8'hFF), plain(8'h00), plain(8'h01),
      plain(8'hFF),
      chk(8'h00, 1'b0, 1, mem_write(SEC_CODE, 16'hFFFF, 16'hFF00)),
      // Relocation past the top address wraps to 0; a zero label byte passes through.
      plain(8'hC3), plain(8'hB7), plain(8'h00), plain(8'h05), plain(8'h00),
      chk(8'h01, 1'b0, 1, mem_write(SEC_FILL, 16'h0000, 16'h0000)),
      chk(8'h00, 1'b0, 2, label_out(16'h0000, 8'h00, 1'b0),
          label_out(16'h0000, 8'h00, 1'b1)),
      // Data section with a count of zero: no writes.
      plain(8'hDA), plain(8'hDA), plain(8'h12), plain(8'h34), plain(8'h00),
      chk(8'h00, 1'b0, 0, '0),
      // Stream cut off after one header byte.
      plain(8'hC3),
      chk(8'h00, 1'b1, 1, stream_end(1'b1))
    };
    foreach (directed[k]) begin
      feed_q.push_back(directed[k]);
    end
    while (feed_q.size() < NumDirected + NumRandom) begin
      add_record();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    idx = 0;
    while (idx < feed_q.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
      while (burst > 0 && idx < feed_q.size()) begin
        // Let everything drain after the directed rows and now and then later on.
        if (idx == NumDirected || (idx % 500 == 0 && idx != 0)) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          wait (pending_results.size() == 0);
          @(posedge clk_i);
        end
        in_valid_i <= 1'b1;
        in_data_i  <= feed_q[idx].item;
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    // Wait so that the results of the last transfer are already expected.
    @(posedge clk_i);

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit, well beyond the clearing pass and the slowest stall pattern.
  initial begin : run_limit
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/olf_pkg.sv
rtl/core/olf_presence.sv
rtl/core/olf_result_queue.sv
rtl/core/olf_parser.sv
rtl/core/object_file_section_loader.sv
dv/object_file_section_loader_test.sv
